// ----- rtl/dlm_pkg.sv -----
// Shared widths, codes and request types of the longest-match scanner.
`default_nettype none

package dlm_pkg;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;
    localparam int LABEL_W = 8;
    localparam int LEN_W   = 16;

    // Table geometry and length limit.
    localparam int STATE_CNT  = 1 << STATE_W;
    localparam int SYMBOL_CNT = 1 << SYM_W;
    localparam int unsigned LEN_MAX = 65535;

    // Parameter defaults.
    localparam int DEF_NUM_STATES = 64;
    localparam int DEF_NUM_LABELS = 256;
    localparam int unsigned DEF_MAX_TOKEN_LEN = 65535;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Opcodes of an input request.
    localparam logic [OP_W-1:0] OP_WRITE_TRANS = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_ATTR  = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN        = 2'd2;

    // Kind of a request that survives classification.
    typedef enum logic [1:0] {
        CMD_TRANS = 2'd0,
        CMD_ATTR  = 2'd1,
        CMD_SCAN  = 2'd2
    } cmd_kind_t;

    // A classified request as it travels through the queue.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [STATE_W-1:0]   state_idx;
        logic [SYM_W-1:0]     sym;
        logic [STATE_W-1:0]   next;
        logic                 present;
        logic                 accept;
        logic [LABEL_W-1:0]   label;
        logic                 eot;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // One transition table entry.
    typedef struct packed {
        logic               present;
        logic [STATE_W-1:0] next;
    } tr_entry_t;

    // One state attribute entry.
    typedef struct packed {
        logic               accept;
        logic [LABEL_W-1:0] label;
    } attr_entry_t;

endpackage

`default_nettype wire

// ----- rtl/dlm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/dlm_front.sv -----
// Front end: accepts input requests, drops the ones with no effect and classifies the rest.
`default_nettype none

module dlm_front #(
    parameter int NUM_STATES = dlm_pkg::DEF_NUM_STATES,
    parameter int NUM_LABELS = dlm_pkg::DEF_NUM_LABELS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [dlm_pkg::OP_W-1:0]    opcode,
    input  wire logic [dlm_pkg::STATE_W-1:0] state_index,
    input  wire logic [dlm_pkg::SYM_W-1:0]   symbol,
    input  wire logic [dlm_pkg::STATE_W-1:0] next_state,
    input  wire logic                        has_transition,
    input  wire logic                        accepting,
    input  wire logic [dlm_pkg::LABEL_W-1:0] state_label,
    input  wire logic                        end_of_text,
    input  wire logic                        hold,
    input  wire dlm_pkg::q_status_t          q_status,
    output logic                             push,
    output dlm_pkg::cmd_t                    push_cmd
);

    import dlm_pkg::*;

    logic front_valid_reg, front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t cls_cmd;
    logic keep;
    logic accept_req;
    logic state_ok;
    logic next_ok;

    // Range checks and label clamp.
    assign state_ok = int'(state_index) < NUM_STATES;
    assign next_ok  = int'(next_state) < NUM_STATES;

    always_comb
    begin
        cls_cmd.kind      = CMD_SCAN;
        cls_cmd.state_idx = state_index;
        cls_cmd.sym       = symbol;
        cls_cmd.next      = next_state;
        cls_cmd.present   = has_transition;
        cls_cmd.accept    = accepting;
        cls_cmd.label     = (int'(state_label) >= NUM_LABELS) ?
                            LABEL_W'(NUM_LABELS - 1) : state_label;
        cls_cmd.eot       = end_of_text;
        keep              = 1'b0;
        case (opcode)
            OP_WRITE_TRANS:
            begin
                cls_cmd.kind = CMD_TRANS;
                keep         = state_ok && next_ok;
            end
            OP_WRITE_ATTR:
            begin
                cls_cmd.kind = CMD_ATTR;
                keep         = state_ok;
            end
            OP_SCAN:
            begin
                cls_cmd.kind = CMD_SCAN;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Handshake: the holding register drains into the queue when it has room.
    assign push       = front_valid_reg && !q_status.full;
    assign push_cmd   = front_cmd_reg;
    assign in_stall   = hold || (front_valid_reg && q_status.full);
    assign accept_req = in_valid && !in_stall;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept_req)
        begin
            front_valid_next = keep;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        if (accept_req)
        begin
            front_cmd_reg <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dlm_queue.sv -----
// Short request queue between the front end and the back end.
`default_nettype none

module dlm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dlm_pkg::cmd_t      push_cmd,
    input  wire logic               pop,
    output dlm_pkg::q_status_t      status,
    output dlm_pkg::cmd_t           head_cmd
);

    import dlm_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign status.full      = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign status.not_empty = count_reg != '0;
    assign head_cmd         = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dlm_back.sv -----
// Back end: table clearing, three-stage scan pipeline and result register.
`default_nettype none

module dlm_back #(
    parameter int          NUM_STATES    = dlm_pkg::DEF_NUM_STATES,
    parameter int unsigned MAX_TOKEN_LEN = dlm_pkg::DEF_MAX_TOKEN_LEN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dlm_pkg::q_status_t          q_status,
    input  wire dlm_pkg::cmd_t               head_cmd,
    output logic                             pop,
    output logic                             clearing,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             matched,
    output logic [dlm_pkg::LABEL_W-1:0]      label,
    output logic [dlm_pkg::LEN_W-1:0]       token_length,
    output logic                             length_saturated
);

    import dlm_pkg::*;

    localparam int NS_EFF   = (NUM_STATES < STATE_CNT) ? NUM_STATES : STATE_CNT;
    localparam int TR_DEPTH = NS_EFF * SYMBOL_CNT;
    localparam int TR_AW    = $clog2(TR_DEPTH);
    localparam int AT_DEPTH = NS_EFF;
    localparam int AT_AW    = $clog2(AT_DEPTH);
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_TOKEN_LEN < LEN_MAX) ? LEN_W'(MAX_TOKEN_LEN) : LEN_W'(LEN_MAX);

    // Work handed from the transition stage to the attribute stage.
    typedef struct packed {
        logic             check;
        logic             emit;
        logic             rearm;
        logic             sat;
        logic [LEN_W-1:0] len;
    } s3_item_t;

    // Clearing pass.
    logic             clear_reg, clear_next;
    logic [TR_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Pipeline control.
    logic adv;
    logic s2_valid_reg, s2_valid_next;
    cmd_t s2_cmd_reg;
    logic s3_valid_reg, s3_valid_next;
    s3_item_t s3_reg, s3_next;

    // Scan state kept at the transition stage.
    logic [STATE_W-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic               sat_reg, sat_next;
    logic               given_reg, given_next;

    // Match state kept at the attribute stage.
    logic               seen_reg, seen_next;
    logic [LEN_W-1:0]   alen_reg, alen_next;
    logic [LABEL_W-1:0] alab_reg, alab_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic               matched_reg;
    logic [LABEL_W-1:0] label_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               lsat_reg;

    // Table ports.
    logic                          tr_we, tr_re;
    logic [TR_AW-1:0]              tr_waddr, tr_raddr;
    logic [$bits(tr_entry_t)-1:0]  tr_wdata, tr_rdata;
    logic [STATE_W+SYM_W-1:0]      tr_wkey, tr_rkey;
    tr_entry_t                     tr_rd;
    logic                          at_we, at_re;
    logic [AT_AW-1:0]              at_waddr, at_raddr;
    logic [$bits(attr_entry_t)-1:0] at_wdata, at_rdata;
    attr_entry_t                   at_rd;

    logic s2_scan;
    logic cnt_room;
    logic hit;
    logic emit;
    logic               seen_cur;
    logic [LEN_W-1:0]   alen_cur;
    logic [LABEL_W-1:0] alab_cur;

    assign clearing = clear_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign pop      = adv && !clear_reg && q_status.not_empty;

    // Clearing pass over the transition table; the attribute table is cleared alongside.
    always_comb
    begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == TR_AW'(TR_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end
    end

    // Transition stage: current state after the request in flight ahead of this one.
    assign tr_rd    = tr_rdata;
    assign s2_scan  = s2_valid_reg && (s2_cmd_reg.kind == CMD_SCAN);
    assign cnt_room = cnt_reg < LEN_CAP;

    always_comb
    begin
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        given_next = given_reg;
        s3_next    = '0;
        at_re      = 1'b0;
        at_raddr   = tr_rd.next[AT_AW-1:0];
        if (s2_scan)
        begin
            if (given_reg)
            begin
                // Bytes after a result are dropped until the end marker rearms.
                if (s2_cmd_reg.eot)
                begin
                    cur_next      = '0;
                    cnt_next      = '0;
                    sat_next      = 1'b0;
                    given_next    = 1'b0;
                    s3_next.rearm = 1'b1;
                end
            end
            else if (!tr_rd.present)
            begin
                // No transition: report what was seen so far.
                s3_next.emit  = 1'b1;
                s3_next.sat   = sat_reg;
                s3_next.rearm = s2_cmd_reg.eot;
                if (s2_cmd_reg.eot)
                begin
                    cur_next = '0;
                    cnt_next = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    given_next = 1'b1;
                end
            end
            else
            begin
                // Byte consumed: step the state, count it and look up the new state.
                s3_next.check = 1'b1;
                s3_next.len   = cnt_room ? cnt_reg + 1'b1 : cnt_reg;
                s3_next.sat   = sat_reg || !cnt_room;
                s3_next.emit  = s2_cmd_reg.eot;
                s3_next.rearm = s2_cmd_reg.eot;
                at_re         = adv;
                if (s2_cmd_reg.eot)
                begin
                    cur_next = '0;
                    cnt_next = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    cur_next = tr_rd.next;
                    cnt_next = s3_next.len;
                    sat_next = s3_next.sat;
                end
            end
        end
    end

    // Issue stage: table writes and the lookup for the request popped from the queue.
    assign tr_wkey  = {head_cmd.state_idx, head_cmd.sym};
    assign tr_rkey  = {cur_next, head_cmd.sym};
    assign tr_we    = clear_reg || (pop && (head_cmd.kind == CMD_TRANS));
    assign tr_waddr = clear_reg ? clr_cnt_reg : tr_wkey[TR_AW-1:0];
    assign tr_wdata = clear_reg ? '0 : {head_cmd.present, head_cmd.next};
    assign tr_re    = pop && (head_cmd.kind == CMD_SCAN);
    assign tr_raddr = tr_rkey[TR_AW-1:0];

    assign at_we    = (clear_reg && (clr_cnt_reg < TR_AW'(AT_DEPTH))) ||
                      (adv && s2_valid_reg && (s2_cmd_reg.kind == CMD_ATTR));
    assign at_waddr = clear_reg ? clr_cnt_reg[AT_AW-1:0] : s2_cmd_reg.state_idx[AT_AW-1:0];
    assign at_wdata = clear_reg ? '0 : {s2_cmd_reg.accept, s2_cmd_reg.label};

    dlm_ram #(
        .WIDTH ($bits(tr_entry_t)),
        .DEPTH (TR_DEPTH)
    ) u_tr_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .re    (tr_re),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    dlm_ram #(
        .WIDTH ($bits(attr_entry_t)),
        .DEPTH (AT_DEPTH)
    ) u_at_ram (
        .clk   (clk),
        .we    (at_we),
        .waddr (at_waddr),
        .wdata (at_wdata),
        .re    (at_re),
        .raddr (at_raddr),
        .rdata (at_rdata)
    );

    // Attribute stage: record an accepting state and form the result.
    assign at_rd    = at_rdata;
    assign hit      = s3_valid_reg && s3_reg.check && at_rd.accept;
    assign seen_cur = seen_reg || hit;
    assign alen_cur = hit ? s3_reg.len : alen_reg;
    assign alab_cur = hit ? at_rd.label : alab_reg;
    assign emit     = s3_valid_reg && s3_reg.emit;

    always_comb
    begin
        seen_next = seen_reg;
        alen_next = alen_reg;
        alab_next = alab_reg;
        if (s3_valid_reg)
        begin
            if (s3_reg.rearm)
            begin
                seen_next = 1'b0;
                alen_next = '0;
                alab_next = '0;
            end
            else
            begin
                seen_next = seen_cur;
                alen_next = alen_cur;
                alab_next = alab_cur;
            end
        end
    end

    // Stage valid bits and result valid.
    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        s3_valid_next  = s3_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            s2_valid_next  = pop;
            s3_valid_next  = s2_scan;
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            given_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            alen_reg      <= '0;
            alab_reg      <= '0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                cur_reg   <= cur_next;
                cnt_reg   <= cnt_next;
                sat_reg   <= sat_next;
                given_reg <= given_next;
                seen_reg  <= seen_next;
                alen_reg  <= alen_next;
                alab_reg  <= alab_next;
            end
        end
    end

    // Pipeline and result payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_cmd_reg <= head_cmd;
            s3_reg     <= s3_next;
            if (emit)
            begin
                matched_reg <= seen_cur;
                label_reg   <= seen_cur ? alab_cur : '0;
                length_reg  <= seen_cur ? alen_cur : '0;
                lsat_reg    <= s3_reg.sat;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign label            = label_reg;
    assign token_length     = length_reg;
    assign length_saturated = lsat_reg;

endmodule

`default_nettype wire

// ----- rtl/dfa_longest_match_scanner.sv -----
// Top level of the table-driven longest-match scanner.
//
//  Channel  Direction  Handshake           Contents
//  in       input      in_valid/in_stall   opcode, state, symbol, transition and attributes
//  out      output     out_valid/out_stall matched, label, token_length, length_saturated
//
// One request is taken per cycle in steady state while no result is held by out_stall;
// a result passes the front register, the queue, the transition stage, the attribute
// stage and the result register. The loop that sets the rate is the transition table:
// its registered read data picks the address of the next byte's lookup directly.
// After reset a clearing pass writes every table entry once, with in_stall held high.
// While a result is presented, out_stall holds the whole back pipeline; the four-entry
// queue and the front register keep taking requests until they fill.
`default_nettype none

module dfa_longest_match_scanner #(
    parameter int          NUM_STATES    = dlm_pkg::DEF_NUM_STATES,
    parameter int          NUM_LABELS    = dlm_pkg::DEF_NUM_LABELS,
    parameter int unsigned MAX_TOKEN_LEN = dlm_pkg::DEF_MAX_TOKEN_LEN
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [dlm_pkg::OP_W-1:0]    opcode,
    input  wire logic [dlm_pkg::STATE_W-1:0] state_index,
    input  wire logic [dlm_pkg::SYM_W-1:0]   symbol,
    input  wire logic [dlm_pkg::STATE_W-1:0] next_state,
    input  wire logic                        has_transition,
    input  wire logic                        accepting,
    input  wire logic [dlm_pkg::LABEL_W-1:0] state_label,
    input  wire logic                        end_of_text,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             matched,
    output logic [dlm_pkg::LABEL_W-1:0]      label,
    output logic [dlm_pkg::LEN_W-1:0]       token_length,
    output logic                             length_saturated
);

    import dlm_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;
    logic      clearing;

    // Front end: accept and classify.
    dlm_front #(
        .NUM_STATES (NUM_STATES),
        .NUM_LABELS (NUM_LABELS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .state_index    (state_index),
        .symbol         (symbol),
        .next_state     (next_state),
        .has_transition (has_transition),
        .accepting      (accepting),
        .state_label    (state_label),
        .end_of_text    (end_of_text),
        .hold           (clearing),
        .q_status       (q_status),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Queue between the two halves.
    dlm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .status   (q_status),
        .head_cmd (head_cmd)
    );

    // Back end: tables, scan pipeline and result register.
    dlm_back #(
        .NUM_STATES    (NUM_STATES),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .head_cmd         (head_cmd),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .label            (label),
        .token_length     (token_length),
        .length_saturated (length_saturated)
    );

    // No result can come out while the tables are being cleared.
    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result presented during the clearing pass");

    // The front end never pushes into a full queue.
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into a full request queue");

    // An unmatched result carries neither label nor length.
    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !matched) |-> (label == '0 && token_length == '0))
        else $error("unmatched result with nonzero label or length");

    // A match always spans at least one byte.
    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && matched) |-> (token_length != '0))
        else $error("matched result with zero length");

endmodule

`default_nettype wire
